@@ rtl/flra_pkg.sv @@
// ----------------------------------------------------------------------------
// flra_pkg
// Types, constants and command/status codes shared by the range allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package flra_pkg;
  localparam int FREE_SLOTS   = 32;
  localparam int HANDLE_SLOTS = 16;
  localparam int ADDR_BITS    = 24;
  localparam int VW           = 25;
  localparam int FIDX_W       = $clog2(FREE_SLOTS);
  localparam int FCNT_W       = $clog2(FREE_SLOTS + 1);
  localparam int HW           = 4;
  localparam logic [VW-1:0] LIMIT = (ADDR_BITS < VW) ? VW'(64'd1 << ADDR_BITS)
                                                     : {VW{1'b1}};
  localparam logic [VW-1:0] INIT_RESET = VW'(65536);

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;
  localparam logic [1:0] ST_NOSPACE = 2'd3;

  // per-cell list operation
  localparam logic [2:0] OP_HOLD   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1; // write start/length at target cell
  localparam logic [2:0] OP_SHL    = 3'd2; // remove target, cells above shift down
  localparam logic [2:0] OP_SHR    = 3'd3; // write start/length at target, cells above shift up
  localparam logic [2:0] OP_RESET  = 3'd4;
  localparam logic [2:0] OP_MERGE2 = 3'd5; // target takes length, target+1 removed

  typedef struct packed {
    logic [1:0]    command;
    logic [VW-1:0] request_bytes;
    logic [HW-1:0] handle_in;
  } flra_in_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [HW-1:0] handle_out;
    logic [VW-1:0] block_offset;
    logic [VW-1:0] block_bytes;
    logic          grew;
  } flra_out_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [FIDX_W-1:0] target;
    logic [VW-1:0]     wr_start;
    logic [VW-1:0]     wr_length;
    logic [VW-1:0]     init_len;
  } flra_ctl_t;
endpackage
`default_nettype wire

@@ rtl/flra_cell.sv @@
// ----------------------------------------------------------------------------
// flra_cell
// One free-list slot: holds a block and follows the shared list operation,
// taking data from its lower or upper neighbor on shifts.
// ----------------------------------------------------------------------------
`default_nettype none
module flra_cell
  import flra_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [FIDX_W-1:0] idx,
  input  wire flra_ctl_t         ctl,
  input  wire logic [VW-1:0]     lo_start,
  input  wire logic [VW-1:0]     lo_length,
  input  wire logic [VW-1:0]     hi_start,
  input  wire logic [VW-1:0]     hi_length,
  output logic      [VW-1:0]     start,
  output logic      [VW-1:0]     length
);
  logic at, above;

  assign at    = (idx == ctl.target);
  assign above = (idx > ctl.target);

  // slot update
  always_ff @(posedge clk) begin
    if (rst) begin
      start  <= '0;
      length <= (idx == '0) ? INIT_RESET : '0;
    end else begin
      case (ctl.op)
        OP_RESET: begin
          start  <= '0;
          length <= (idx == '0) ? ctl.init_len : '0;
        end
        OP_LOAD: begin
          if (at) begin
            start  <= ctl.wr_start;
            length <= ctl.wr_length;
          end
        end
        OP_SHL: begin
          if (at || above) begin
            start  <= hi_start;
            length <= hi_length;
          end
        end
        OP_MERGE2: begin
          if (at) begin
            length <= ctl.wr_length;
          end else if (above) begin
            start  <= hi_start;
            length <= hi_length;
          end
        end
        OP_SHR: begin
          if (at) begin
            start  <= ctl.wr_start;
            length <= ctl.wr_length;
          end else if (above) begin
            start  <= lo_start;
            length <= lo_length;
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/free_list_range_allocator.sv @@
// ----------------------------------------------------------------------------
// free_list_range_allocator
// Byte-range allocator: sorted free list held in a chain of cells, handle
// table in registers, growth of capacity and coalescing on free.
// ----------------------------------------------------------------------------
// an accepted start passes the search and update states; result_valid is registered
// a new command is taken only once idle again; busy covers search and update
// the fit and position searches run across all cells in the search cycle
// reset (rst, synchronous) gives one free block of INIT_RESET bytes at offset zero,
// a config write one of capped cfg_data (none for zero); results cannot be stalled
`default_nettype none
module free_list_range_allocator
  import flra_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire flra_in_t      command_in,
  input  wire logic          cfg_we,
  input  wire logic [VW-1:0] cfg_data,
  output logic               result_valid,
  output flra_out_t          result
);
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0]      state;
  flra_in_t        cmd;
  logic [VW-1:0]   cfg_sat;
  logic [VW-1:0]   capacity;
  logic [FCNT_W-1:0] free_count;
  logic [HW-1:0]   next_handle;
  logic [HANDLE_SLOTS-1:0] live_valid;
  logic [VW-1:0]   live_start  [HANDLE_SLOTS];
  logic [VW-1:0]   live_length [HANDLE_SLOTS];

  logic [VW-1:0]   fs [FREE_SLOTS];
  logic [VW-1:0]   fl [FREE_SLOTS];
  flra_ctl_t       ctl;

  // search results registered
  logic              fit_found;
  logic [FIDX_W-1:0] fit_idx;
  logic [FCNT_W-1:0] pos;

  // config value saturated at the address limit
  assign cfg_sat = (cfg_data > LIMIT) ? LIMIT : cfg_data;

  // cell chain
  for (genvar g = 0; g < FREE_SLOTS; g++) begin : g_cell
    logic [VW-1:0] ls, ll, hs, hl;
    if (g == 0) begin : g_lo0
      assign ls = '0;
      assign ll = '0;
    end else begin : g_lo
      assign ls = fs[g-1];
      assign ll = fl[g-1];
    end
    if (g == FREE_SLOTS-1) begin : g_hiN
      assign hs = '0;
      assign hl = '0;
    end else begin : g_hi
      assign hs = fs[g+1];
      assign hl = fl[g+1];
    end
    flra_cell u_cell (
      .clk(clk), .rst(rst), .idx(FIDX_W'(g)), .ctl(ctl),
      .lo_start(ls), .lo_length(ll), .hi_start(hs), .hi_length(hl),
      .start(fs[g]), .length(fl[g])
    );
  end

  // highest fitting block and insert position, parallel over cells
  logic              fit_c;
  logic [FIDX_W-1:0] fit_idx_c;
  logic [FCNT_W-1:0] pos_c;
  logic [VW-1:0]     bs_c;
  always_comb begin
    fit_c     = 1'b0;
    fit_idx_c = '0;
    pos_c     = '0;
    bs_c      = live_start[cmd.handle_in];
    for (int i = 0; i < FREE_SLOTS; i++) begin
      if (FCNT_W'(i) < free_count) begin
        if (fl[i] >= cmd.request_bytes) begin
          fit_c     = 1'b1;
          fit_idx_c = FIDX_W'(i);
        end
        if (fs[i] <= bs_c) pos_c = FCNT_W'(i + 1);
      end
    end
  end

  // update decode
  logic [FIDX_W-1:0] last;
  logic [FIDX_W-1:0] pm1;
  logic [FIDX_W-1:0] pi;
  logic [VW:0]       cap_sum;
  logic [VW-1:0]     bl, bs;
  logic              left, right, hlive;
  flra_out_t         res;
  logic              do_res;
  logic              set_live, clr_live;
  logic              cnt_inc, cnt_dec;
  logic [VW-1:0]     cap_next;

  assign last    = FIDX_W'(free_count - 1'b1);
  assign pi      = FIDX_W'(pos);
  assign pm1     = FIDX_W'(pos - 1'b1);
  assign cap_sum = {1'b0, capacity} + {1'b0, cmd.request_bytes};
  assign bs      = live_start[cmd.handle_in];
  assign bl      = live_length[cmd.handle_in];
  assign hlive   = live_valid[cmd.handle_in];
  assign left    = (pos != '0) && (fs[pm1] + fl[pm1] == bs);
  assign right   = (pos < free_count) && (bs + bl == fs[pi]);

  always_comb begin
    ctl          = '0;
    ctl.op       = OP_HOLD;
    ctl.init_len = cfg_sat;
    res          = '0;
    set_live     = 1'b0;
    clr_live     = 1'b0;
    cnt_inc      = 1'b0;
    cnt_dec      = 1'b0;
    cap_next     = capacity;
    do_res       = (state == S_UPDATE);
    if (cfg_we) begin
      ctl.op = OP_RESET;
    end else if (state == S_UPDATE) begin
      case (cmd.command)
        CMD_ALLOC: begin
          if (live_valid[next_handle]) begin
            res.status     = ST_BUSY;
            res.handle_out = next_handle;
          end else if (fit_found) begin
            res.handle_out   = next_handle;
            res.block_offset = fs[fit_idx];
            res.block_bytes  = cmd.request_bytes;
            set_live         = 1'b1;
            ctl.target       = fit_idx;
            if (fl[fit_idx] == cmd.request_bytes) begin
              ctl.op  = OP_SHL;
              cnt_dec = 1'b1;
            end else begin
              ctl.op        = OP_LOAD;
              ctl.wr_start  = fs[fit_idx] + cmd.request_bytes;
              ctl.wr_length = fl[fit_idx] - cmd.request_bytes;
            end
          end else if (cap_sum > {1'b0, LIMIT}) begin
            res.status = ST_NOSPACE;
          end else if (cmd.request_bytes == '0) begin
            res.handle_out   = next_handle;
            res.block_offset = capacity;
            res.grew         = 1'b1;
            set_live         = 1'b1;
          end else if (free_count != '0 && fs[last] + fl[last] == capacity) begin
            // grow merges into last block, then carve its start
            res.handle_out   = next_handle;
            res.block_offset = fs[last];
            res.block_bytes  = cmd.request_bytes;
            res.grew         = 1'b1;
            set_live         = 1'b1;
            cap_next         = cap_sum[VW-1:0];
            ctl.target       = last;
            if (fl[last] == '0) begin
              ctl.op  = OP_SHL;
              cnt_dec = 1'b1;
            end else begin
              ctl.op        = OP_LOAD;
              ctl.wr_start  = fs[last] + cmd.request_bytes;
              ctl.wr_length = fl[last];
            end
          end else if (free_count < FCNT_W'(FREE_SLOTS)) begin
            // appended block consumed entirely
            res.handle_out   = next_handle;
            res.block_offset = capacity;
            res.block_bytes  = cmd.request_bytes;
            res.grew         = 1'b1;
            set_live         = 1'b1;
            cap_next         = cap_sum[VW-1:0];
          end else begin
            res.status = ST_NOSPACE;
          end
        end
        CMD_FREE: begin
          res.handle_out = cmd.handle_in;
          if (!hlive) begin
            res.status = ST_INVALID;
          end else if (bl == '0) begin
            clr_live = 1'b1;
          end else if (left && right) begin
            ctl.op        = OP_MERGE2;
            ctl.target    = pm1;
            ctl.wr_length = fl[pm1] + bl + fl[pi];
            cnt_dec       = 1'b1;
            clr_live      = 1'b1;
          end else if (left) begin
            ctl.op        = OP_LOAD;
            ctl.target    = pm1;
            ctl.wr_start  = fs[pm1];
            ctl.wr_length = fl[pm1] + bl;
            clr_live      = 1'b1;
          end else if (right) begin
            ctl.op        = OP_LOAD;
            ctl.target    = pi;
            ctl.wr_start  = bs;
            ctl.wr_length = fl[pi] + bl;
            clr_live      = 1'b1;
          end else if (free_count >= FCNT_W'(FREE_SLOTS)) begin
            res.status = ST_NOSPACE;
          end else begin
            ctl.op        = OP_SHR;
            ctl.target    = pi;
            ctl.wr_start  = bs;
            ctl.wr_length = bl;
            cnt_inc       = 1'b1;
            clr_live      = 1'b1;
          end
        end
        CMD_LOOKUP: begin
          res.handle_out = cmd.handle_in;
          if (!hlive) begin
            res.status = ST_INVALID;
          end else begin
            res.block_offset = bs;
            res.block_bytes  = bl;
          end
        end
        default: begin
          res.status     = ST_INVALID;
          res.handle_out = cmd.handle_in;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // control and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      capacity      <= INIT_RESET;
      free_count    <= FCNT_W'(1);
      next_handle   <= '0;
      live_valid    <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= do_res && !cfg_we;
      if (cfg_we) begin
        capacity      <= cfg_sat;
        free_count    <= (cfg_data == '0) ? '0 : FCNT_W'(1);
        next_handle   <= '0;
        live_valid    <= '0;
        state         <= S_IDLE;
      end else begin
        case (state)
          S_IDLE: begin
            if (start) state <= S_SEARCH;
          end
          S_SEARCH: state <= S_UPDATE;
          S_UPDATE: begin
            state    <= S_IDLE;
            capacity <= cap_next;
            if (cnt_inc) free_count <= free_count + 1'b1;
            if (cnt_dec) free_count <= free_count - 1'b1;
            if (set_live) begin
              live_valid[next_handle] <= 1'b1;
              next_handle <= HW'((32'(next_handle) + 1) % HANDLE_SLOTS);
            end
            if (clr_live) live_valid[cmd.handle_in] <= 1'b0;
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) cmd <= command_in;
    if (state == S_SEARCH) begin
      fit_found <= fit_c;
      fit_idx   <= fit_idx_c;
      pos       <= pos_c;
    end
    if (set_live && !cfg_we) begin
      live_start[next_handle]  <= res.block_offset;
      live_length[next_handle] <= res.block_bytes;
    end
    result <= res;
  end
endmodule
`default_nettype wire
